/* rtl/logistic_regression_sgd_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the logistic regression engine
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LOGISTIC_REGRESSION_SGD_DEFINES_SVH
`define LOGISTIC_REGRESSION_SGD_DEFINES_SVH

// Same-cycle implication.
`define LRS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lrs assertion failed");

// Next-cycle implication.
`define LRS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lrs assertion failed");

`endif

/* rtl/lrs_pkg.sv */
// ---------------------------------------------------------------------------
// Logistic regression engine package
// Defaults, state codes, store control type and the sigmoid table builder.
// ---------------------------------------------------------------------------
package lrs_pkg;

   localparam int MAX_FEATURES_DEF    = 16;
   localparam int SIGMOID_ENTRIES_DEF = 256;
   localparam int FRACTION_BITS_DEF   = 16;

   localparam logic [15:0] RATE_RESET = 16'd655;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_ZSUM,
      ST_LOOK,
      ST_PROB,
      ST_GAIN,
      ST_BIAS,
      ST_UREAD,
      ST_UMUL,
      ST_UADD,
      ST_UWRITE
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic w_we;
      logic s_we;
   } store_ctl_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sh007FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -40'sh0080000000) begin
         r = -32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Unsigned long division by shift and subtract, for elaboration only.
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned dvs);
      longint unsigned q;
      longint unsigned rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= dvs) begin
            rem  = rem - dvs;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Sigmoid table entry k of n, evaluated during elaboration only.
   function automatic logic [15:0] sig_entry(input int k, input int n);
      longint one;
      longint r;
      longint sum;
      longint term;
      longint unsigned mag;
      longint unsigned den;
      longint unsigned p;
      int d;
      logic neg;
      one  = longint'(1) <<< 30;
      d    = 2 * k - n;
      neg  = (d < 0);
      mag  = neg ? longint'(-d) : longint'(d);
      r    = longint'(udiv64(mag << 30, 64'(n)));
      sum  = one;
      term = one;
      for (int i = 1; i <= 20; i++) begin
         term = longint'(udiv64(longint'((longint'(term) * longint'(r)) >> 30), 64'(i)));
         if (i[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > one) begin
         sum = one;
      end
      for (int s = 0; s < 3; s++) begin
         sum = longint'((longint'(sum) * longint'(sum)) >> 30);
      end
      den = longint'(one) + longint'(sum);
      p   = udiv64((64'd1 << 46) + (den >> 1), den);
      if (neg) begin
         p = 64'd65536 - p;
      end
      if (p > 64'd65535) begin
         p = 64'd65535;
      end
      return p[15:0];
   endfunction

endpackage

/* rtl/lrs_store.sv */
// ---------------------------------------------------------------------------
// Weight and sample store
// Two single-port synchronous memories; weights carry valid bits so that an
// entry never written reads as zero after reset.
// ---------------------------------------------------------------------------
module lrs_store #(
   parameter int MAX_FEATURES = lrs_pkg::MAX_FEATURES_DEF,
   parameter int AW           = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lrs_pkg::store_ctl_type ctl,
   input  logic [AW-1:0]         addr,
   input  logic signed [31:0]    w_wdata,
   input  logic signed [31:0]    s_wdata,
   output logic signed [31:0]    w_rdata,
   output logic signed [31:0]    s_rdata
);

   logic signed [31:0] w_mem [MAX_FEATURES];
   logic signed [31:0] s_mem [MAX_FEATURES];

   logic [MAX_FEATURES-1:0] wval_ff, wval_in;
   logic signed [31:0]      w_rd_ff;
   logic signed [31:0]      s_rd_ff;
   logic                    rdval_ff;

   always_comb begin
      wval_in = wval_ff;
      if (ctl.w_we) begin
         wval_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wval_ff <= '0;
      end else begin
         wval_ff <= wval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.w_we) begin
         w_mem[addr] <= w_wdata;
      end
      if (ctl.s_we) begin
         s_mem[addr] <= s_wdata;
      end
      if (ctl.rd_en) begin
         w_rd_ff  <= w_mem[addr];
         s_rd_ff  <= s_mem[addr];
         rdval_ff <= wval_ff[addr];
      end
   end

   assign w_rdata = rdval_ff ? w_rd_ff : '0;
   assign s_rdata = s_rd_ff;

endmodule

/* rtl/lrs_sigmoid.sv */
// ---------------------------------------------------------------------------
// Sigmoid lookup
// Maps the weighted sum to a table index over [-8,8), registers the index
// and reads the constant table.
// ---------------------------------------------------------------------------
module lrs_sigmoid #(
   parameter int SIGMOID_ENTRIES = lrs_pkg::SIGMOID_ENTRIES_DEF,
   parameter int FRACTION_BITS   = lrs_pkg::FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic signed [63:0] z,
   output logic [15:0]        prob
);

   localparam int IW = $clog2(SIGMOID_ENTRIES);
   localparam int OW = FRACTION_BITS + 4;
   localparam int PW = OW + $clog2(SIGMOID_ENTRIES + 1);
   localparam logic signed [63:0] EIGHT = 64'sd8 <<< FRACTION_BITS;
   localparam logic [PW-OW-1:0]   LIMIT = (PW-OW)'(SIGMOID_ENTRIES);
   localparam logic [IW-1:0]      TOP   = IW'(SIGMOID_ENTRIES - 1);

   logic [15:0] tbl [SIGMOID_ENTRIES];

   for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_tbl
      assign tbl[k] = lrs_pkg::sig_entry(k, SIGMOID_ENTRIES);
   end

   logic signed [63:0] off;
   logic [PW-1:0]      prod;
   logic [IW-1:0]      idx_ff, idx_in;

   assign off  = z + EIGHT;
   assign prod = PW'(off[OW-1:0]) * PW'(SIGMOID_ENTRIES);

   always_comb begin
      if (z < -EIGHT) begin
         idx_in = '0;
      end else if (z >= EIGHT) begin
         idx_in = TOP;
      end else if (prod[PW-1:OW] >= LIMIT) begin
         idx_in = TOP;
      end else begin
         idx_in = prod[OW+IW-1:OW];
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   assign prob = tbl[idx_ff];

endmodule

/* rtl/logistic_regression_sgd.sv */
// ---------------------------------------------------------------------------
// Logistic regression engine with stochastic gradient descent
// Sums weight times feature per sample, maps the sum through a sigmoid table
// and, for training samples, updates bias and weights in place.
// ---------------------------------------------------------------------------
//
//   channel  | ports                        | one transfer carries
//   ---------+------------------------------+------------------------------
//   req      | req_valid / req_ready        | one feature, kind, last, label
//   rsp      | rsp_valid / rsp_ready        | one result per sample
//   csr      | csr_valid / csr_ready        | learning rate
//
// A feature passes the weight memory read, the 32x32 multiply and the
// accumulate, and a closing one goes on to the bias add, the index and the
// table read with the result load. A training sample then runs a gain and
// a bias step and a read, multiply, add and write per stored feature over
// the weight memory's single read/write port. The result sits in an output
// register, so a stalled rsp channel only holds the engine when a second
// result is ready. Reset is synchronous; weights read as zero until written.
//
`include "logistic_regression_sgd_defines.svh"

module logistic_regression_sgd #(
   parameter int MAX_FEATURES    = lrs_pkg::MAX_FEATURES_DEF,
   parameter int SIGMOID_ENTRIES = lrs_pkg::SIGMOID_ENTRIES_DEF,
   parameter int FRACTION_BITS   = lrs_pkg::FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic signed [31:0] req_feature,
   input  logic               req_last,
   input  logic               req_label,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [16:0]        rsp_probability,
   output logic               rsp_predicted_class,
   output logic signed [17:0] rsp_prediction_error,
   output logic               rsp_too_many_features,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_learning_rate
);

   localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CW = $clog2(MAX_FEATURES + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FEATURES);
   localparam int GW = 35;

   lrs_pkg::state_type state_ff, state_in;

   // Control state.
   logic [CW-1:0]      pos_ff, pos_in;
   logic               ovf_ff, ovf_in;
   logic signed [63:0] sum_ff, sum_in;
   logic signed [31:0] bias_ff, bias_in;
   logic [15:0]        rate_ff, rate_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic signed [31:0] feat_ff, feat_in;
   logic               kind_ff, kind_in;
   logic               last_ff, last_in;
   logic               label_ff, label_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] z_ff, z_in;
   logic signed [17:0] err_ff, err_in;
   logic signed [GW-1:0] g_ff, g_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      j_ff, j_in;
   logic signed [50:0] ph_ff, ph_in;
   logic signed [51:0] pl_ff, pl_in;
   logic signed [31:0] wold_ff, wold_in;
   logic signed [35:0] wd_ff, wd_in;
   logic [16:0]        prob_ff, prob_in;
   logic               cls_ff, cls_in;
   logic signed [17:0] perr_ff, perr_in;
   logic               tmf_ff, tmf_in;

   // Store and table signals.
   lrs_pkg::store_ctl_type ctl;
   logic [AW-1:0]      addr;
   logic signed [31:0] w_wdata;
   logic signed [31:0] w_rdata;
   logic signed [31:0] s_rdata;
   logic [15:0]        prob;

   logic accept;
   logic active;
   logic load;
   logic signed [17:0] err_now;
   logic signed [39:0] bias_delta;
   logic signed [67:0] wfull;

   lrs_store #(
      .MAX_FEATURES(MAX_FEATURES),
      .AW          (AW)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .addr   (addr),
      .w_wdata(w_wdata),
      .s_wdata(req_feature),
      .w_rdata(w_rdata),
      .s_rdata(s_rdata)
   );

   lrs_sigmoid #(
      .SIGMOID_ENTRIES(SIGMOID_ENTRIES),
      .FRACTION_BITS  (FRACTION_BITS)
   ) u_sigmoid (
      .clock(clock),
      .z    (z_ff),
      .prob (prob)
   );

   assign req_ready = (state_ff == lrs_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign active    = (pos_ff < CNT_MAX);
   // A result may enter the output register when it is empty or draining.
   assign load      = (state_ff == lrs_pkg::ST_PROB) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lrs_pkg::ST_IDLE: begin
            if (accept) begin
               if (active) begin
                  state_in = lrs_pkg::ST_MUL;
               end else if (req_last) begin
                  state_in = lrs_pkg::ST_ZSUM;
               end
            end
         end
         lrs_pkg::ST_MUL:  state_in = lrs_pkg::ST_ACC;
         lrs_pkg::ST_ACC: begin
            state_in = last_ff ? lrs_pkg::ST_ZSUM : lrs_pkg::ST_IDLE;
         end
         lrs_pkg::ST_ZSUM: state_in = lrs_pkg::ST_LOOK;
         lrs_pkg::ST_LOOK: state_in = lrs_pkg::ST_PROB;
         lrs_pkg::ST_PROB: begin
            if (load) begin
               state_in = kind_ff ? lrs_pkg::ST_IDLE : lrs_pkg::ST_GAIN;
            end
         end
         lrs_pkg::ST_GAIN: state_in = lrs_pkg::ST_BIAS;
         lrs_pkg::ST_BIAS: begin
            state_in = (cnt_ff != '0) ? lrs_pkg::ST_UREAD : lrs_pkg::ST_IDLE;
         end
         lrs_pkg::ST_UREAD: state_in = lrs_pkg::ST_UMUL;
         lrs_pkg::ST_UMUL:  state_in = lrs_pkg::ST_UADD;
         lrs_pkg::ST_UADD:  state_in = lrs_pkg::ST_UWRITE;
         lrs_pkg::ST_UWRITE: begin
            state_in = (j_ff + 1'b1 == cnt_ff) ? lrs_pkg::ST_IDLE : lrs_pkg::ST_UREAD;
         end
         default: state_in = lrs_pkg::ST_IDLE;
      endcase
   end

   // Store control.
   always_comb begin
      ctl.rd_en = (accept && active) || (state_ff == lrs_pkg::ST_UREAD);
      ctl.s_we  = accept && active;
      ctl.w_we  = (state_ff == lrs_pkg::ST_UWRITE);
      if ((state_ff == lrs_pkg::ST_UREAD) || (state_ff == lrs_pkg::ST_UWRITE)) begin
         addr = j_ff[AW-1:0];
      end else begin
         addr = pos_ff[AW-1:0];
      end
   end

   assign w_wdata = lrs_pkg::sat32(40'(wold_ff) - 40'(wd_ff));

   // Error of the closing item; predict-only samples report zero.
   always_comb begin
      if (kind_ff) begin
         err_now = '0;
      end else if (label_ff) begin
         err_now = 18'($signed({2'b00, prob})) - 18'sd65536;
      end else begin
         err_now = 18'($signed({2'b00, prob}));
      end
   end

   assign bias_delta = (40'(g_ff) + (40'sd1 <<< (31 - FRACTION_BITS)))
                       >>> (32 - FRACTION_BITS);
   assign wfull = (68'(ph_ff) <<< 16) + 68'(pl_ff) + (68'sd1 <<< 31);

   // Datapath.
   always_comb begin
      pos_in   = pos_ff;
      ovf_in   = ovf_ff;
      sum_in   = sum_ff;
      bias_in  = bias_ff;
      rate_in  = rate_ff;
      feat_in  = feat_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      label_in = label_ff;
      prod_in  = prod_ff;
      z_in     = z_ff;
      err_in   = err_ff;
      g_in     = g_ff;
      cnt_in   = cnt_ff;
      j_in     = j_ff;
      ph_in    = ph_ff;
      pl_in    = pl_ff;
      wold_in  = wold_ff;
      wd_in    = wd_ff;
      prob_in  = prob_ff;
      cls_in   = cls_ff;
      perr_in  = perr_ff;
      tmf_in   = tmf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid && csr_ready) begin
         rate_in = csr_learning_rate;
      end

      if (accept) begin
         feat_in  = req_feature;
         kind_in  = req_kind;
         last_in  = req_last;
         label_in = req_label;
         if (active) begin
            pos_in = pos_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end

      case (state_ff)
         lrs_pkg::ST_MUL: begin
            prod_in = 64'(w_rdata) * 64'(feat_ff);
         end
         lrs_pkg::ST_ACC: begin
            sum_in = sum_ff + (prod_ff >>> FRACTION_BITS);
         end
         lrs_pkg::ST_ZSUM: begin
            z_in = sum_ff + 64'(bias_ff);
         end
         lrs_pkg::ST_PROB: begin
            if (load) begin
               prob_in      = {1'b0, prob};
               cls_in       = prob[15];
               perr_in      = err_now;
               tmf_in       = ovf_ff;
               err_in       = err_now;
               rsp_valid_in = 1'b1;
               cnt_in       = pos_ff;
               j_in         = '0;
               pos_in       = '0;
               ovf_in       = 1'b0;
               sum_in       = '0;
            end
         end
         lrs_pkg::ST_GAIN: begin
            g_in = GW'($signed({1'b0, rate_ff}) * err_ff);
         end
         lrs_pkg::ST_BIAS: begin
            bias_in = lrs_pkg::sat32(40'(bias_ff) - bias_delta);
         end
         lrs_pkg::ST_UMUL: begin
            // Feature split into a signed high half and an unsigned low half.
            ph_in   = 51'(g_ff * $signed(s_rdata[31:16]));
            pl_in   = 52'(g_ff * $signed({1'b0, s_rdata[15:0]}));
            wold_in = w_rdata;
         end
         lrs_pkg::ST_UADD: begin
            wd_in = wfull[67:32];
         end
         lrs_pkg::ST_UWRITE: begin
            j_in = j_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrs_pkg::ST_IDLE;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
         bias_ff      <= '0;
         rate_ff      <= lrs_pkg::RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         bias_ff      <= bias_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      feat_ff  <= feat_in;
      kind_ff  <= kind_in;
      last_ff  <= last_in;
      label_ff <= label_in;
      prod_ff  <= prod_in;
      z_ff     <= z_in;
      err_ff   <= err_in;
      g_ff     <= g_in;
      cnt_ff   <= cnt_in;
      j_ff     <= j_in;
      ph_ff    <= ph_in;
      pl_ff    <= pl_in;
      wold_ff  <= wold_in;
      wd_ff    <= wd_in;
      prob_ff  <= prob_in;
      cls_ff   <= cls_in;
      perr_ff  <= perr_in;
      tmf_ff   <= tmf_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_probability       = prob_ff;
   assign rsp_predicted_class   = cls_ff;
   assign rsp_prediction_error  = perr_ff;
   assign rsp_too_many_features = tmf_ff;

   // The feature count never passes the store depth.
   `LRS_ASSERT_IMP(a_pos_bound, 1'b1, pos_ff <= CNT_MAX)
   // Ignored features only appear once the store is full.
   `LRS_ASSERT_IMP(a_ovf_full, ovf_ff, pos_ff == CNT_MAX)
   // The update pass only writes entries filled by the sample.
   `LRS_ASSERT_IMP(a_pass_range, state_ff == lrs_pkg::ST_UWRITE, j_ff < cnt_ff)
   // A loaded result is presented and the sample state starts over.
   `LRS_ASSERT_NXT(a_load_clear, load, rsp_valid_ff && (pos_ff == '0) && !ovf_ff)

endmodule
